// ===== rtl/core/bsps_pkg.sv =====
package bsps_pkg;

   localparam int WINDOW_HALF_DEF = 5;
   localparam int HEIGHT_BAND_DEF = 64;
   localparam int COORD_BITS_DEF  = 12;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 64;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_SHADOW_COLUMN,
      CSR_PLAYER_X,
      CSR_PLAYER_Y,
      CSR_PLAYER_Z,
      CSR_ROW0_XY,
      CSR_ROW0_ZW,
      CSR_ROW1_XY,
      CSR_ROW1_ZW
   } csr_reg_type;

   localparam logic [7:0]  FLAG_SHADOWED = 8'h08;
   localparam logic [7:0]  FLAG_CLEAR    = 8'h44;
   localparam logic [7:0]  DZ_NEAR       = 8'd180;
   localparam logic [7:0]  DZ_FAR        = 8'd255;
   localparam logic [15:0] QUANT_MUL     = 16'd249;
   localparam logic [15:0] QUANT_BIAS    = 16'd1014;

   // Q16.16 value of 2.0, Q32.32 of 2.0 and of 181.0
   localparam int                  TWO_Q16     = 2 << 16;
   localparam logic [35:0]         SQ_LIMIT    = 36'd2 << 32;
   localparam logic signed [51:0]  SHADE_LIMIT = 52'sd181 <<< 32;

   typedef struct packed {
      logic [11:0]        pixel_x;
      logic [11:0]        pixel_y;
      logic signed [31:0] sample_height;
      logic [15:0]        visual_in;
      logic [7:0]         flags_in;
      logic [7:0]         diffuse_in;
      logic [7:0]         bg_red;
      logic [7:0]         bg_green;
      logic [7:0]         bg_blue;
   } req_payload_type;

   typedef struct packed {
      logic [15:0] visual_out;
      logic [7:0]  flags_out;
      logic [7:0]  diffuse_out;
      logic        shadowed;
   } rsp_payload_type;

   typedef struct packed {
      logic signed [12:0] shadow_column;
      logic signed [31:0] player_x;
      logic signed [31:0] player_y;
      logic signed [31:0] player_z;
      logic [63:0]        row0_xy;
      logic [63:0]        row0_zw;
      logic [63:0]        row1_xy;
      logic [63:0]        row1_zw;
   } cfg_type;

   typedef struct packed {
      logic [15:0] visual;
      logic [7:0]  flags;
      logic [7:0]  diffuse;
      logic [7:0]  diffuse_dim;
      logic [14:0] colour;
   } pass_type;

   typedef struct packed {
      logic               cand;
      logic signed [44:0] px0;
      logic signed [44:0] py0;
      logic signed [63:0] pz0;
      logic signed [44:0] px1;
      logic signed [44:0] py1;
      logic signed [63:0] pz1;
      logic signed [32:0] dh;
      pass_type           pass;
   } front_type;

   typedef struct packed {
      logic               in_range;
      logic signed [18:0] dx;
      logic signed [18:0] dy;
      logic signed [32:0] dh;
      pass_type           pass;
   } map_type;

   // 8-bit channel to 5 bits: (c*249 + 1014) >> 11
   function automatic logic [4:0] requant(input logic [7:0] c);
      logic [15:0] t;
      t = 16'(c) * QUANT_MUL + QUANT_BIAS;
      return t[15:11];
   endfunction

   // floor(d*180/255), with p/255 taken as (p + (p >> 8) + 1) >> 8
   function automatic logic [7:0] dim_near(input logic [7:0] d);
      logic [15:0] p;
      logic [16:0] s;
      p = 16'(d) * 16'(DZ_NEAR);
      s = 17'(p) + 17'(p >> 8) + 17'd1;
      return s[15:8];
   endfunction

endpackage

// ===== rtl/core/bsps_front.sv =====
module bsps_front #(
   parameter int WINDOW_HALF = bsps_pkg::WINDOW_HALF_DEF,
   parameter int HEIGHT_BAND = bsps_pkg::HEIGHT_BAND_DEF,
   parameter int COORD_BITS  = bsps_pkg::COORD_BITS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   input  bsps_pkg::req_payload_type in_data,
   input  bsps_pkg::cfg_type         cfg,
   output logic                      out_valid,
   output bsps_pkg::front_type       out_data
);

   localparam logic [16:0]        COORD_LIM = 17'(1) << COORD_BITS;
   localparam logic signed [13:0] WIN       = 14'(WINDOW_HALF);
   localparam logic signed [32:0] BAND      = 33'(HEIGHT_BAND) <<< 16;

   logic                valid_ff, valid_in;
   bsps_pkg::front_type data_ff, data_in;

   logic signed [13:0] col_diff;
   logic signed [12:0] x13;
   logic signed [12:0] y13;
   logic               win_ok;
   logic               coord_ok;
   logic               band_ok;

   always_comb begin
      col_diff = $signed({2'b00, in_data.pixel_x}) - 14'(cfg.shadow_column);
      x13      = $signed({1'b0, in_data.pixel_x});
      y13      = $signed({1'b0, in_data.pixel_y});
      win_ok   = (col_diff <= WIN) && (col_diff >= -WIN);
      coord_ok = (17'(in_data.pixel_x) < COORD_LIM) && (17'(in_data.pixel_y) < COORD_LIM);

      data_in.dh = 33'(in_data.sample_height) - 33'(cfg.player_z);
      band_ok    = (data_in.dh <= BAND) && (data_in.dh >= -BAND);
      data_in.cand = win_ok && coord_ok && band_ok;

      data_in.px0 = $signed(cfg.row0_xy[31:0]) * x13;
      data_in.py0 = $signed(cfg.row0_xy[63:32]) * y13;
      data_in.pz0 = $signed(cfg.row0_zw[31:0]) * in_data.sample_height;
      data_in.px1 = $signed(cfg.row1_xy[31:0]) * x13;
      data_in.py1 = $signed(cfg.row1_xy[63:32]) * y13;
      data_in.pz1 = $signed(cfg.row1_zw[31:0]) * in_data.sample_height;

      data_in.pass.visual      = in_data.visual_in;
      data_in.pass.flags       = in_data.flags_in;
      data_in.pass.diffuse     = in_data.diffuse_in;
      data_in.pass.diffuse_dim = bsps_pkg::dim_near(in_data.diffuse_in);
      data_in.pass.colour      = {bsps_pkg::requant(in_data.bg_blue),
                                  bsps_pkg::requant(in_data.bg_green),
                                  bsps_pkg::requant(in_data.bg_red)};
      valid_in = in_valid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// ===== rtl/core/bsps_map.sv =====
module bsps_map (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  bsps_pkg::front_type in_data,
   input  bsps_pkg::cfg_type   cfg,
   output logic                out_valid,
   output bsps_pkg::map_type   out_data
);

   // partial sums: products of x and y, and scaled height plus offset minus player
   logic                  sum_valid_ff, sum_valid_in;
   logic signed [45:0]    a0_ff, a0_in, a1_ff, a1_in;
   logic signed [49:0]    b0_ff, b0_in, b1_ff, b1_in;
   logic                  cand_ff, cand_in;
   logic signed [32:0]    dh_ff, dh_in;
   bsps_pkg::pass_type    pass_ff, pass_in;

   logic                  valid_ff, valid_in;
   bsps_pkg::map_type     data_ff, data_in;

   logic signed [50:0]    d0;
   logic signed [50:0]    d1;
   logic                  ok0;
   logic                  ok1;

   always_comb begin
      sum_valid_in = in_valid;
      a0_in   = 46'(in_data.px0) + 46'(in_data.py0);
      a1_in   = 46'(in_data.px1) + 46'(in_data.py1);
      b0_in   = 50'(in_data.pz0 >>> 16) + 50'($signed(cfg.row0_zw[63:32]))
                - 50'(cfg.player_x);
      b1_in   = 50'(in_data.pz1 >>> 16) + 50'($signed(cfg.row1_zw[63:32]))
                - 50'(cfg.player_y);
      cand_in = in_data.cand;
      dh_in   = in_data.dh;
      pass_in = in_data.pass;
   end

   always_comb begin
      d0  = 51'(a0_ff) + 51'(b0_ff);
      d1  = 51'(a1_ff) + 51'(b1_ff);
      ok0 = (d0 <= 51'(bsps_pkg::TWO_Q16)) && (d0 >= -51'(bsps_pkg::TWO_Q16));
      ok1 = (d1 <= 51'(bsps_pkg::TWO_Q16)) && (d1 >= -51'(bsps_pkg::TWO_Q16));
      valid_in         = sum_valid_ff;
      data_in.in_range = cand_ff && ok0 && ok1;
      data_in.dx       = $signed(d0[18:0]);
      data_in.dy       = $signed(d1[18:0]);
      data_in.dh       = dh_ff;
      data_in.pass     = pass_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_valid_ff <= 1'b0;
         valid_ff     <= 1'b0;
      end else begin
         sum_valid_ff <= sum_valid_in;
         valid_ff     <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      a0_ff   <= a0_in;
      a1_ff   <= a1_in;
      b0_ff   <= b0_in;
      b1_ff   <= b1_in;
      cand_ff <= cand_in;
      dh_ff   <= dh_in;
      pass_ff <= pass_in;
      data_ff <= data_in;
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// ===== rtl/core/bsps_shade.sv =====
module bsps_shade (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   input  bsps_pkg::map_type         in_data,
   output logic                      out_strobe,
   output bsps_pkg::rsp_payload_type out_data
);

   logic                      sq_valid_ff, sq_valid_in;
   logic [34:0]               sq0_ff, sq0_in, sq1_ff, sq1_in;
   logic                      in_range_ff, in_range_in;
   logic signed [32:0]        dh_ff, dh_in;
   bsps_pkg::pass_type        pass_ff, pass_in;

   logic                      strobe_ff, strobe_in;
   bsps_pkg::rsp_payload_type rsp_ff, rsp_in;

   logic signed [37:0] prod0;
   logic signed [37:0] prod1;
   logic [35:0]        sq;
   logic signed [51:0] level;
   logic               hit;
   logic               near;

   always_comb begin
      prod0       = in_data.dx * in_data.dx;
      prod1       = in_data.dy * in_data.dy;
      sq_valid_in = in_valid;
      sq0_in      = prod0[34:0];
      sq1_in      = prod1[34:0];
      in_range_in = in_data.in_range;
      dh_in       = in_data.dh;
      pass_in     = in_data.pass;
   end

   always_comb begin
      sq    = 36'(sq0_ff) + 36'(sq1_ff);
      hit   = in_range_ff && (sq <= bsps_pkg::SQ_LIMIT);
      // shade level 2*(pz - h) + 2*sq in Q32.32
      level = $signed({15'b0, sq, 1'b0}) - 52'($signed({dh_ff, 17'b0}));
      near  = level < bsps_pkg::SHADE_LIMIT;

      strobe_in          = sq_valid_ff;
      rsp_in.visual_out  = pass_ff.visual;
      rsp_in.flags_out   = pass_ff.flags;
      rsp_in.diffuse_out = pass_ff.diffuse;
      rsp_in.shadowed    = hit;
      if (hit) begin
         if ((pass_ff.flags & bsps_pkg::FLAG_SHADOWED) != 8'h00) begin
            // already dark: scale diffuse by dz/255
            rsp_in.diffuse_out = near ? pass_ff.diffuse_dim : pass_ff.diffuse;
         end else begin
            rsp_in.visual_out  = {1'b0, pass_ff.colour};
            rsp_in.flags_out   = (pass_ff.flags | bsps_pkg::FLAG_SHADOWED)
                                 & ~bsps_pkg::FLAG_CLEAR;
            rsp_in.diffuse_out = near ? bsps_pkg::DZ_NEAR : bsps_pkg::DZ_FAR;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_valid_ff <= 1'b0;
         strobe_ff   <= 1'b0;
      end else begin
         sq_valid_ff <= sq_valid_in;
         strobe_ff   <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      sq0_ff      <= sq0_in;
      sq1_ff      <= sq1_in;
      in_range_ff <= in_range_in;
      dh_ff       <= dh_in;
      pass_ff     <= pass_in;
      rsp_ff      <= rsp_in;
   end

   assign out_strobe = strobe_ff;
   assign out_data   = rsp_ff;

endmodule

// ===== rtl/core/blob_shadow_pixel_shader.sv =====
// Channel    Ports                            Transfer at clock edge when
// request    start, busy, req_data            start high and busy low
// response   rsp_strobe, rsp_data             rsp_strobe high (one-cycle strobe per result)
// config     csr_we, csr_index, csr_wdata     csr_we high
//
// One sample per cycle while busy is low; each result passes through the five register
// stages: products, partial sums, offset and range, squares, output.
// Reset is synchronous: it clears the valid bits and the configuration registers and
// holds busy high until the cycle after reset falls.
// Results are never held back: the receiver must take every result as it is shown; the block does not enforce this.
module blob_shadow_pixel_shader #(
   parameter int WINDOW_HALF = bsps_pkg::WINDOW_HALF_DEF,
   parameter int HEIGHT_BAND = bsps_pkg::HEIGHT_BAND_DEF,
   parameter int COORD_BITS  = bsps_pkg::COORD_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  bsps_pkg::req_payload_type            req_data,
   output logic                                 rsp_strobe,
   output bsps_pkg::rsp_payload_type            rsp_data,
   input  logic                                 csr_we,
   input  logic [bsps_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [bsps_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   bsps_pkg::cfg_type   cfg_ff, cfg_in;
   logic                busy_ff, busy_in;

   logic                accept;
   logic                front_valid;
   bsps_pkg::front_type front_data;
   logic                map_valid;
   bsps_pkg::map_type   map_data;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (bsps_pkg::csr_reg_type'(csr_index))
            bsps_pkg::CSR_SHADOW_COLUMN: cfg_in.shadow_column = $signed(csr_wdata[12:0]);
            bsps_pkg::CSR_PLAYER_X:      cfg_in.player_x      = $signed(csr_wdata[31:0]);
            bsps_pkg::CSR_PLAYER_Y:      cfg_in.player_y      = $signed(csr_wdata[31:0]);
            bsps_pkg::CSR_PLAYER_Z:      cfg_in.player_z      = $signed(csr_wdata[31:0]);
            bsps_pkg::CSR_ROW0_XY:       cfg_in.row0_xy       = csr_wdata;
            bsps_pkg::CSR_ROW0_ZW:       cfg_in.row0_zw       = csr_wdata;
            bsps_pkg::CSR_ROW1_XY:       cfg_in.row1_xy       = csr_wdata;
            bsps_pkg::CSR_ROW1_ZW:       cfg_in.row1_zw       = csr_wdata;
            default:                     cfg_in = cfg_ff;
         endcase
      end
      busy_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff  <= '0;
         busy_ff <= 1'b1;
      end else begin
         cfg_ff  <= cfg_in;
         busy_ff <= busy_in;
      end
   end

   assign busy   = busy_ff;
   assign accept = start && !busy_ff;

   bsps_front #(
      .WINDOW_HALF (WINDOW_HALF),
      .HEIGHT_BAND (HEIGHT_BAND),
      .COORD_BITS  (COORD_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .in_data   (req_data),
      .cfg       (cfg_ff),
      .out_valid (front_valid),
      .out_data  (front_data)
   );

   bsps_map u_map (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_data   (front_data),
      .cfg       (cfg_ff),
      .out_valid (map_valid),
      .out_data  (map_data)
   );

   bsps_shade u_shade (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (map_valid),
      .in_data    (map_data),
      .out_strobe (rsp_strobe),
      .out_data   (rsp_data)
   );

   // every transfer in comes out as a result strobe
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##5 rsp_strobe)
      else $error("result missing five cycles after request transfer");

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy, 5))
      else $error("result without a matching request transfer");

   a_flag_set: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.shadowed) |-> rsp_data.flags_out[3])
      else $error("shadowed result without shadow flag");

   a_pass_visual: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_data.shadowed) |->
         (rsp_data.visual_out == $past(req_data.visual_in, 5)))
      else $error("pass-through visual word altered");

endmodule
